### rtl/core/fee_pkg.sv
package fee_pkg;

   // Configuration register indexes and reset values
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_MASK_LOW  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_MASK_HIGH = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  ESCAPE_MASK_LOW_RESET  = 64'hD400_8425_FFFF_FFFF;
   localparam logic [CSR_DATA_W-1:0]  ESCAPE_MASK_HIGH_RESET = 64'h9000_0000_1000_0000;

   // Characters of the escape sequences
   localparam logic [15:0] CHAR_PERCENT = 16'h0025;
   localparam logic [15:0] CHAR_PLUS    = 16'h002B;
   localparam logic [15:0] CHAR_ZERO    = 16'h0030;
   localparam logic [15:0] CHAR_ALPHA   = 16'h0037;  // 'A' minus ten

   // Position codes inside an escape sequence
   localparam logic [2:0] POS_FIRST  = 3'd0;
   localparam logic [2:0] POS_SECOND = 3'd1;
   localparam logic [2:0] POS_THIRD  = 3'd2;
   localparam logic [2:0] POS_FOURTH = 3'd3;
   localparam logic [2:0] POS_FIFTH  = 3'd4;
   localparam logic [2:0] POS_SIXTH  = 3'd5;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_final;
   } req_type;

   typedef struct packed {
      logic [15:0] out_unit;
      logic        run_end;
      logic        string_end;
   } rsp_type;

   // One queue entry: the units that one item releases, already classified
   typedef struct packed {
      logic [15:0] j0_unit;
      logic        j0_esc;
      logic [15:0] j1_unit;
      logic        j1_esc;
      logic        two;
      logic        final_unit;
   } job_type;

   function automatic logic is_lead(input logic [15:0] u);
      return u[15:10] == 6'b110110;
   endfunction

   function automatic logic is_trail(input logic [15:0] u);
      return u[15:10] == 6'b110111;
   endfunction

   function automatic logic must_escape(input logic [15:0]  cur,
                                        input logic [15:0]  prev,
                                        input logic [15:0]  next,
                                        input logic [127:0] mask);
      logic esc;
      esc = 1'b0;
      if (cur[15:7] == 9'd0) begin
         esc = mask[cur[6:0]];
      end else if (is_lead(cur) && !is_trail(next)) begin
         esc = 1'b1;
      end else if (is_trail(cur) && !is_lead(prev)) begin
         esc = 1'b1;
      end
      return esc;
   endfunction

   function automatic logic [15:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? (CHAR_ZERO + {12'd0, v}) : (CHAR_ALPHA + {12'd0, v});
   endfunction

endpackage

### rtl/core/fee_front.sv
module fee_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fee_pkg::req_type                    req_data,
   input  logic                                csr_write_enable,
   input  logic [fee_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fee_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                push_valid,
   input  logic                                push_ready,
   output fee_pkg::job_type                    push_data
);
   import fee_pkg::*;

   logic [CSR_DATA_W-1:0] mask_low_ff, mask_low_in;
   logic [CSR_DATA_W-1:0] mask_high_ff, mask_high_in;
   logic [15:0]           held_unit_ff, held_unit_in;
   logic                  held_valid_ff, held_valid_in;
   logic [15:0]           prior_unit_ff, prior_unit_in;
   logic [15:0]           prev_of_unit;
   logic                  accept;
   logic [127:0]          mask;

   assign mask      = {mask_high_ff, mask_low_ff};
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   // An item that is only held releases nothing
   assign push_valid = req_valid && (held_valid_ff || req_data.is_final);

   always_comb begin
      prev_of_unit = held_valid_ff ? held_unit_ff : prior_unit_ff;

      push_data.j0_unit    = held_valid_ff ? held_unit_ff : req_data.code_unit;
      push_data.j0_esc     = held_valid_ff
                           ? must_escape(held_unit_ff, prior_unit_ff, req_data.code_unit, mask)
                           : must_escape(req_data.code_unit, prev_of_unit, 16'h0000, mask);
      push_data.j1_unit    = req_data.code_unit;
      push_data.j1_esc     = must_escape(req_data.code_unit, prev_of_unit, 16'h0000, mask);
      push_data.two        = held_valid_ff && req_data.is_final;
      push_data.final_unit = req_data.is_final;

      held_unit_in  = held_unit_ff;
      held_valid_in = held_valid_ff;
      prior_unit_in = prior_unit_ff;
      if (accept) begin
         if (req_data.is_final) begin
            held_unit_in  = 16'h0000;
            held_valid_in = 1'b0;
            prior_unit_in = 16'h0000;
         end else begin
            held_unit_in  = req_data.code_unit;
            held_valid_in = 1'b1;
            prior_unit_in = prev_of_unit;
         end
      end

      mask_low_in  = mask_low_ff;
      mask_high_in = mask_high_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ESCAPE_MASK_LOW:  mask_low_in  = csr_write_data;
            CSR_ESCAPE_MASK_HIGH: mask_high_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_low_ff   <= ESCAPE_MASK_LOW_RESET;
         mask_high_ff  <= ESCAPE_MASK_HIGH_RESET;
         held_unit_ff  <= 16'h0000;
         held_valid_ff <= 1'b0;
         prior_unit_ff <= 16'h0000;
      end else begin
         mask_low_ff   <= mask_low_in;
         mask_high_ff  <= mask_high_in;
         held_unit_ff  <= held_unit_in;
         held_valid_ff <= held_valid_in;
         prior_unit_ff <= prior_unit_in;
      end
   end

endmodule

### rtl/core/fee_queue.sv
module fee_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  fee_pkg::job_type  push_data,
   output logic              pop_valid,
   input  logic              pop,
   output fee_pkg::job_type  pop_data
);
   import fee_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/fee_back.sv
module fee_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  fee_pkg::job_type  head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fee_pkg::rsp_type  rsp_data
);
   import fee_pkg::*;

   logic        job_ff, job_in;
   logic [2:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [15:0] cur_unit;
   logic        cur_esc;
   logic        cur_long;
   logic [2:0]  last_pos;
   logic        unit_last;
   logic        entry_last;
   logic        advance;
   logic [15:0] sym;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      cur_unit   = job_ff ? head.j1_unit : head.j0_unit;
      cur_esc    = job_ff ? head.j1_esc  : head.j0_esc;
      cur_long   = cur_unit[15:8] != 8'd0;
      last_pos   = !cur_esc ? POS_FIRST : (cur_long ? POS_SIXTH : POS_THIRD);
      unit_last  = pos_ff == last_pos;
      entry_last = unit_last && (job_ff || !head.two);
      advance    = head_valid && (!rsp_valid_ff || rsp_ready);
      pop        = advance && entry_last;

      sym = cur_unit;
      if (cur_esc) begin
         case (pos_ff)
            POS_FIRST:  sym = CHAR_PERCENT;
            POS_SECOND: sym = cur_long ? CHAR_PLUS : hex_digit(cur_unit[7:4]);
            POS_THIRD:  sym = cur_long ? hex_digit(cur_unit[15:12]) : hex_digit(cur_unit[3:0]);
            POS_FOURTH: sym = hex_digit(cur_unit[11:8]);
            POS_FIFTH:  sym = hex_digit(cur_unit[7:4]);
            POS_SIXTH:  sym = hex_digit(cur_unit[3:0]);
            default:    sym = cur_unit;
         endcase
      end

      job_in       = job_ff;
      pos_in       = pos_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_unit   = sym;
         rsp_data_in.run_end    = entry_last;
         rsp_data_in.string_end = entry_last && head.final_unit;
         if (unit_last) begin
            pos_in = POS_FIRST;
            job_in = !entry_last;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff       <= 1'b0;
         pos_ff       <= POS_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_ff       <= job_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/filename_escape_encoder_core.sv
// The job an accepted item releases passes through the job queue and the output
//    register; a unit that is only held releases its results with the next item.
// Throughput: one item per cycle while the job queue has room; the output shows
//    one unit per cycle unless stalled; an escaped unit becomes three or six units.
// The output rate is set by the back end's unit serialiser; a four-entry job
//    queue lets the front keep taking items while the back drains escapes.
module filename_escape_encoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fee_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fee_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_enable,
   input  logic [fee_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fee_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import fee_pkg::*;

   // Reset (synchronous, active high) empties queue and output, clears the held
   // unit and its predecessor, and restores both escape masks.

   // Front to queue: jobs released by each item
   logic    push_valid;
   logic    push_ready;
   job_type push_data;

   // Queue to back: oldest pending job
   logic    head_valid;
   logic    pop;
   job_type head;

   // Front: hold each non-final unit until its successor arrives, classify it against
   // the escape mask and surrogate pairing, and release one job of one or two units
   fee_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // Queue: decouple classification from serialisation
   fee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop        (pop),
      .pop_data   (head)
   );

   // Back: expand each job into plain or %XX / %+XXXX units, one per cycle while
   // the output is not stalled, and present them in a registered output stage
   fee_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import fee_pkg::*;

   // Idle chance per cycle on each side, in percent
   localparam int IDLE_PCT      = 6;
   // Length of the long receiver hold-off, in cycles
   localparam int HOLD_CYCLES   = 60;
   // Cycles to let pass once the last result is in, before touching the masks
   localparam int SETTLE_CYCLES = 4;
   // Cycles without any item moving on either channel before giving up
   localparam int STALL_LIMIT   = 2000;

   // Top six bits of a lead and of a trail surrogate
   localparam logic [5:0] LEAD_TAG  = 6'b110110;
   localparam logic [5:0] TRAIL_TAG = 6'b110111;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ESCAPE_MASK_LOW;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   filename_escape_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Encoder prediction: our own copy of the held unit, its predecessor
   // and the 128-bit escape mask (high register on top).
   // ------------------------------------------------------------------
   logic [15:0]  pred_held_unit  = '0;
   logic         pred_held_valid = 1'b0;
   logic [15:0]  pred_prior_unit = '0;
   logic [127:0] pred_escape_mask = {ESCAPE_MASK_HIGH_RESET, ESCAPE_MASK_LOW_RESET};

   logic [15:0]  encoded_run[$];     // units released by the item in hand
   rsp_type      expected_units[$];  // results still owed by the block
   rsp_type      expected_head;
   int           mismatch_count = 0;

   // Control shared with the receiver process; written with nonblocking
   // assignments so the receiver always sees the value from before the edge.
   bit           rx_no_gaps = 1'b0;
   int           hold_requests = 0;
   int           hold_served = 0;
   int           hold_left = 0;
   // Owned by the sending process alone
   bit           tx_no_gaps = 1'b0;

   function automatic logic [15:0] hex_char(input logic [3:0] nibble);
      return (nibble < 4'd10) ? CHAR_ZERO + 16'(nibble) : CHAR_ALPHA + 16'(nibble);
   endfunction

   // ASCII goes by the mask; a surrogate escapes when it has no partner
   // on the side where its partner should stand.
   function automatic logic escape_needed(input logic [15:0] cur,
                                          input logic [15:0] prev,
                                          input logic [15:0] next);
      if (cur[15:7] == 9'd0)
         return pred_escape_mask[cur[6:0]];
      if (cur[15:10] == LEAD_TAG && next[15:10] != TRAIL_TAG)
         return 1'b1;
      if (cur[15:10] == TRAIL_TAG && prev[15:10] != LEAD_TAG)
         return 1'b1;
      return 1'b0;
   endfunction

   function automatic void append_encoded(input logic [15:0] cur,
                                          input logic [15:0] prev,
                                          input logic [15:0] next);
      if (!escape_needed(cur, prev, next)) begin
         encoded_run.push_back(cur);
      end else if (cur[15:8] == 8'd0) begin
         // short form: %XX
         encoded_run.push_back(CHAR_PERCENT);
         encoded_run.push_back(hex_char(cur[7:4]));
         encoded_run.push_back(hex_char(cur[3:0]));
      end else begin
         // long form: %+XXXX
         encoded_run.push_back(CHAR_PERCENT);
         encoded_run.push_back(CHAR_PLUS);
         encoded_run.push_back(hex_char(cur[15:12]));
         encoded_run.push_back(hex_char(cur[11:8]));
         encoded_run.push_back(hex_char(cur[7:4]));
         encoded_run.push_back(hex_char(cur[3:0]));
      end
   endfunction

   // Work out the results of one accepted item and queue them up
   function automatic void predict_encoding(input logic [15:0] unit_in,
                                            input logic        last_in);
      logic [15:0] before_unit;
      rsp_type     entry;
      int          last_pos;
      encoded_run.delete();
      before_unit = pred_prior_unit;
      // The successor has arrived: release the held unit
      if (pred_held_valid) begin
         append_encoded(pred_held_unit, pred_prior_unit, unit_in);
         before_unit = pred_held_unit;
      end
      if (last_in) begin
         // End of string: nothing follows, so flush this unit too and start afresh
         append_encoded(unit_in, before_unit, 16'h0000);
         pred_held_unit  = '0;
         pred_held_valid = 1'b0;
         pred_prior_unit = '0;
      end else begin
         pred_prior_unit = before_unit;
         pred_held_unit  = unit_in;
         pred_held_valid = 1'b1;
      end
      last_pos = encoded_run.size() - 1;
      foreach (encoded_run[i]) begin
         entry.out_unit   = encoded_run[i];
         entry.run_end    = (i == last_pos);
         entry.string_end = last_in && (i == last_pos);
         expected_units.push_back(entry);
      end
   endfunction

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------

   // Offer one item, idling first at random, and hold it until taken.
   // Valid is left high; whoever stops sending lowers it.
   task automatic send_unit(input logic [15:0] unit_in, input logic last_in);
      if (!tx_no_gaps) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{code_unit: unit_in, is_final: last_in};
      do @(posedge clock); while (!req_ready);
      predict_encoding(unit_in, last_in);
   endtask

   // Send a whole string, the flag on its last unit
   task automatic send_string(input logic [15:0] text[$]);
      foreach (text[i])
         send_unit(text[i], i == text.size() - 1);
   endtask

   // Drop valid, wait until every owed result is in, then let the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_units.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Load both mask registers; only ever called between strings, block idle
   task automatic load_masks(input logic [CSR_DATA_W-1:0] mask_low,
                             input logic [CSR_DATA_W-1:0] mask_high);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ESCAPE_MASK_LOW;
      csr_write_data   <= mask_low;
      @(posedge clock);
      csr_index        <= CSR_ESCAPE_MASK_HIGH;
      csr_write_data   <= mask_high;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pred_escape_mask = {mask_high, mask_low};
   endtask

   // Bias towards ASCII, Latin-1 and surrogates, where the behaviour lives
   function automatic logic [15:0] random_unit();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40)
         return 16'($urandom_range(127));
      else if (pick < 50)
         return 16'($urandom_range(255, 128));
      else if (pick < 62)
         return {LEAD_TAG, 10'($urandom)};
      else if (pick < 74)
         return {TRAIL_TAG, 10'($urandom)};
      return 16'($urandom);
   endfunction

   // Random strings of 1 to 12 units, each position but the last starting a
   // well-formed surrogate pair one time in five; the last string is cut to fit the count
   task automatic run_random_strings(input int item_count);
      int sent;
      int len;
      int pos;
      sent = 0;
      while (sent < item_count) begin
         len = $urandom_range(12, 1);
         if (len > item_count - sent)
            len = item_count - sent;
         pos = 0;
         while (pos < len) begin
            if (pos + 1 < len && $urandom_range(99) < 20) begin
               send_unit({LEAD_TAG, 10'($urandom)}, 1'b0);
               send_unit({TRAIL_TAG, 10'($urandom)}, pos + 2 == len);
               pos += 2;
            end else begin
               send_unit(random_unit(), pos + 1 == len);
               pos += 1;
            end
         end
         sent += len;
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked strings under the reset masks
   task automatic test_directed_cases();
      logic [15:0] text[$];
      // a one-unit string: NUL is escaped by the reset mask
      text = '{16'h0000};
      send_string(text);
      // plain letter, DEL (escaped), and the top of Latin-1 which never escapes
      text = '{16'h0041, 16'h007F, 16'h0080, 16'h00FF};
      send_string(text);
      // trail at string start, lone lead, lone trail, a proper pair,
      // and a lead left dangling at the end
      text = '{16'hDC00, 16'hD800, 16'h0078, 16'hDFFF, 16'hDBFF, 16'hDC00, 16'hD834};
      send_string(text);
      // top code unit, percent sign itself, first unit beyond Latin-1
      text = '{16'hFFFF, 16'h0025, 16'h0100};
      send_string(text);
   endtask

   task automatic test_reset_masks_random();
      run_random_strings(100);
   endtask

   // Nothing escaped, then every ASCII code escaped, then back to reset values
   task automatic test_mask_extremes();
      logic [15:0] text[$];
      text = '{16'h0000, 16'h0025, 16'h003F, 16'h0040, 16'h005C, 16'h007F, 16'h0080};
      load_masks('0, '0);
      send_string(text);
      load_masks('1, '1);
      send_string(text);
      load_masks(ESCAPE_MASK_LOW_RESET, ESCAPE_MASK_HIGH_RESET);
   endtask

   // Stop the receiver for a long stretch while escape-heavy items keep
   // coming, so the job queue fills and the input stalls; then pause the
   // sender until every result is back.
   task automatic test_output_backpressure();
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 0)
            send_unit(random_unit(), i == 29);
         else
            send_unit({LEAD_TAG, 10'($urandom)}, (i % 2 == 1) || (i == 29));
      end
      wait_drained();
   endtask

   // Random masks: even, sparse and dense
   task automatic test_random_masks();
      logic [CSR_DATA_W-1:0] low_bits;
      logic [CSR_DATA_W-1:0] high_bits;
      for (int round = 0; round < 3; round++) begin
         low_bits  = {$urandom, $urandom};
         high_bits = {$urandom, $urandom};
         if (round == 1) begin
            low_bits  &= {$urandom, $urandom};
            high_bits &= {$urandom, $urandom};
         end else if (round == 2) begin
            low_bits  |= {$urandom, $urandom};
            high_bits |= {$urandom, $urandom};
         end
         load_masks(low_bits, high_bits);
         run_random_strings(75);
      end
   endtask

   // A long stretch with neither side idling
   task automatic test_steady_stream();
      rx_no_gaps <= 1'b1;
      tx_no_gaps = 1'b1;
      run_random_strings(90);
      wait_drained();
      rx_no_gaps <= 1'b0;
      tx_no_gaps = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_reset_masks_random();
      test_mask_extremes();
      test_output_backpressure();
      test_random_masks();
      test_steady_stream();
      wait_drained();
      if (mismatch_count == 0 && expected_units.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver side
   // ------------------------------------------------------------------

   // Drive ready: serve a requested hold-off first, else idle at random
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_ready   <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES - 1;
      end else begin
         rsp_ready <= rx_no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Compare every accepted result with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_units.size() == 0) begin
            $display("%0t: result with none owed, out_unit %h", $time, rsp_data.out_unit);
            mismatch_count++;
         end else begin
            expected_head = expected_units.pop_front();
            if (rsp_data.out_unit !== expected_head.out_unit) begin
               $display("%0t: out_unit expected %h actual %h",
                        $time, expected_head.out_unit, rsp_data.out_unit);
               mismatch_count++;
            end
            if (rsp_data.run_end !== expected_head.run_end) begin
               $display("%0t: run_end expected %b actual %b",
                        $time, expected_head.run_end, rsp_data.run_end);
               mismatch_count++;
            end
            if (rsp_data.string_end !== expected_head.string_end) begin
               $display("%0t: string_end expected %b actual %b",
                        $time, expected_head.string_end, rsp_data.string_end);
               mismatch_count++;
            end
         end
      end
   end

   // Give up when nothing moves on either channel for too long
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
rtl/core/fee_pkg.sv
rtl/core/fee_front.sv
rtl/core/fee_queue.sv
rtl/core/fee_back.sv
rtl/core/filename_escape_encoder_core.sv
bench/tb_top.sv
